@@ design/gbcs_pkg.sv @@
// Shared types, widths, register indexes and codes for the grid bucket corner selector.
package gbcs_pkg;

  // Field widths.
  localparam int unsigned POS_W   = 12;
  localparam int unsigned LVL_W   = 3;
  localparam int unsigned SCORE_W = 16;
  localparam int unsigned CIDX_W  = 10;
  localparam int unsigned MODE_W  = 2;
  localparam int unsigned CS_W    = 9;
  localparam int unsigned GC_W    = 11;
  localparam int unsigned KEY_W   = 24;

  // Configuration port.
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_CELL_SIZE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_COLUMNS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SCORE_THRESH = 2'd2;

  localparam logic [CS_W-1:0]    CELL_SIZE_RST    = 9'd32;
  localparam logic [GC_W-1:0]    GRID_COLUMNS_RST = 11'd20;
  localparam logic [SCORE_W-1:0] SCORE_THRESH_RST = 16'd320;

  // Item modes.
  localparam logic [MODE_W-1:0] MODE_MARK  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_OFFER = 2'd1;
  localparam logic [MODE_W-1:0] MODE_DRAIN = 2'd2;

  // Default sizes.
  localparam int unsigned MAX_CELLS_DEF  = 1024;
  localparam int unsigned MAX_LEVELS_DEF = 8;

  // Stored winner of one cell, x in the low bits.
  typedef struct packed {
    logic [SCORE_W-1:0] score;
    logic [LVL_W-1:0]   level;
    logic [POS_W-1:0]   y;
    logic [POS_W-1:0]   x;
  } entry_t;

  // One word of the cell memory.
  typedef struct packed {
    logic   occupied;
    logic   valid;
    entry_t entry;
  } cell_word_t;

  // Result of the two-lane divider.
  typedef struct packed {
    logic             done;
    logic [POS_W-1:0] qx;
    logic [POS_W-1:0] qy;
  } div_res_t;

endpackage

@@ design/gbcs_div.sv @@
// Two-lane restoring divider that bins x and y by the cell size, one quotient bit per cycle.
module gbcs_div
  import gbcs_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [CS_W-1:0]  divisor_i,
  input  logic [POS_W-1:0] dividend_x_i,
  input  logic [POS_W-1:0] dividend_y_i,
  output div_res_t         res_o
);

  localparam int unsigned CntW = $clog2(POS_W);

  logic            run_q, run_d;
  logic            done_q, done_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [CS_W-1:0] dvs_q;
  logic [POS_W-1:0] quo_x_q, quo_x_d, quo_y_q, quo_y_d;
  logic [CS_W-1:0]  rem_x_q, rem_x_d, rem_y_q, rem_y_d;
  logic [CS_W:0]    sh_x, sh_y;
  logic             ge_x, ge_y;

  // One restoring step in each lane.
  always_comb begin
    sh_x = {rem_x_q, quo_x_q[POS_W-1]};
    sh_y = {rem_y_q, quo_y_q[POS_W-1]};
    ge_x = sh_x >= {1'b0, dvs_q};
    ge_y = sh_y >= {1'b0, dvs_q};
  end

  // Step control: load on start, then POS_W steps.
  always_comb begin
    run_d   = run_q;
    done_d  = 1'b0;
    cnt_d   = cnt_q;
    quo_x_d = quo_x_q;
    quo_y_d = quo_y_q;
    rem_x_d = rem_x_q;
    rem_y_d = rem_y_q;
    if (start_i) begin
      run_d   = 1'b1;
      cnt_d   = '0;
      quo_x_d = dividend_x_i;
      quo_y_d = dividend_y_i;
      rem_x_d = '0;
      rem_y_d = '0;
    end else if (run_q) begin
      quo_x_d = {quo_x_q[POS_W-2:0], ge_x};
      quo_y_d = {quo_y_q[POS_W-2:0], ge_y};
      rem_x_d = ge_x ? CS_W'(sh_x - {1'b0, dvs_q}) : sh_x[CS_W-1:0];
      rem_y_d = ge_y ? CS_W'(sh_y - {1'b0, dvs_q}) : sh_y[CS_W-1:0];
      cnt_d   = cnt_q + 1'b1;
      if (cnt_q == CntW'(POS_W - 1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvs_q <= divisor_i;
    end
    quo_x_q <= quo_x_d;
    quo_y_q <= quo_y_d;
    rem_x_q <= rem_x_d;
    rem_y_q <= rem_y_d;
  end

  assign res_o.done = done_q;
  assign res_o.qx   = quo_x_q;
  assign res_o.qy   = quo_y_q;

endmodule

@@ design/grid_bucket_corner_select.sv @@
// Top level of the grid bucket corner selector: cell memory, sequencer and result register.
//
//   channel   direction  handshake                  payload
//   item      in         start & !busy              mode_i pos_x_i pos_y_i level_i score_i
//                                                   cell_index_i
//   result    out        result_valid_o (1 cycle)   found_o out_x_o out_y_o out_level_o
//   config    in         cfg_we_i                   cfg_idx_i cfg_data_i
//
// A mark or an offer passes the two-lane cell-size divider (load, 12 steps and the done
// flag), then the row times columns multiply, the memory read and the write-back.
// A drain goes through a memory read, then a write-back; its result beat follows in the
// next cycle. An offer dropped for its level or scaled position, and an unused mode, leave
// the sequencer idle. After reset a clearing pass writes every one of the MAX_CELLS memory
// words, one per cycle, with busy high. The result beat cannot be stalled by the receiver.
module grid_bucket_corner_select
  import gbcs_pkg::*;
#(
  parameter int unsigned MAX_CELLS  = MAX_CELLS_DEF,
  parameter int unsigned MAX_LEVELS = MAX_LEVELS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  logic [MODE_W-1:0]     mode_i,
  input  logic [POS_W-1:0]      pos_x_i,
  input  logic [POS_W-1:0]      pos_y_i,
  input  logic [LVL_W-1:0]      level_i,
  input  logic [SCORE_W-1:0]    score_i,
  input  logic [CIDX_W-1:0]     cell_index_i,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output logic                  result_valid_o,
  output logic                  found_o,
  output logic [POS_W-1:0]      out_x_o,
  output logic [POS_W-1:0]      out_y_o,
  output logic [LVL_W-1:0]      out_level_o
);

  localparam int unsigned IdxW  = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;
  localparam int unsigned WordW = $bits(cell_word_t);
  localparam logic [KEY_W-1:0] MaxCellsK = KEY_W'(MAX_CELLS);
  localparam logic [LVL_W:0]   MaxLevelsK = (LVL_W + 1)'(MAX_LEVELS);
  localparam int unsigned ScW = POS_W + (1 << LVL_W) - 1;

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_DIV   = 3'd2;
  localparam logic [2:0] ST_MUL   = 3'd3;
  localparam logic [2:0] ST_READ  = 3'd4;
  localparam logic [2:0] ST_MOD   = 3'd5;

  // Configuration registers.
  logic [CS_W-1:0]    bin_size_q;
  logic [GC_W-1:0]    grid_cols_q;
  logic [SCORE_W-1:0] thresh_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bin_size_q  <= CELL_SIZE_RST;
      grid_cols_q <= GRID_COLUMNS_RST;
      thresh_q    <= SCORE_THRESH_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_CELL_SIZE:    bin_size_q  <= cfg_data_i[CS_W-1:0];
        CFG_GRID_COLUMNS: grid_cols_q <= cfg_data_i[GC_W-1:0];
        CFG_SCORE_THRESH: thresh_q    <= cfg_data_i;
        default:          ;
      endcase
    end
  end

  logic [2:0]         state_q, state_d;
  logic [IdxW-1:0]    clr_q, clr_d;
  logic [MODE_W-1:0]  mode_q;
  logic [POS_W-1:0]   x_q, y_q;
  logic [LVL_W-1:0]   lvl_q;
  logic [SCORE_W-1:0] score_q;
  logic [KEY_W-1:0]   key_q, key_d;
  logic               ok_q, ok_d;

  logic               accept;
  logic [ScW-1:0]     sx_wide, sy_wide;
  logic [POS_W-1:0]   bin_x, bin_y;
  logic               drop;
  logic               div_start;
  logic [CS_W-1:0]    cs_eff;
  div_res_t           div_res;

  logic [POS_W+GC_W-1:0] prod;
  logic [KEY_W-1:0]      key_sum;

  cell_word_t         rd_q;
  cell_word_t         wr_word;
  logic               mem_we;
  logic [IdxW-1:0]    mem_wa;
  logic [WordW-1:0]   mem_q [MAX_CELLS];

  logic               res_valid_d, found_d;
  logic               res_valid_q, found_q;
  logic [POS_W-1:0]   out_x_q, out_y_q;
  logic [LVL_W-1:0]   out_lvl_q;
  entry_t             new_entry;

  assign busy   = (state_q != ST_IDLE);
  assign accept = start && !busy;

  // Input decode: scaling for offers, early drop of offers and unused mode.
  always_comb begin
    sx_wide = ScW'(pos_x_i) << level_i;
    sy_wide = ScW'(pos_y_i) << level_i;
    if (mode_i == MODE_OFFER) begin
      bin_x = sx_wide[POS_W-1:0];
      bin_y = sy_wide[POS_W-1:0];
    end else begin
      bin_x = pos_x_i;
      bin_y = pos_y_i;
    end
    drop = 1'b0;
    if (mode_i == MODE_OFFER) begin
      drop = ({1'b0, level_i} >= MaxLevelsK) || (|sx_wide[ScW-1:POS_W])
          || (|sy_wide[ScW-1:POS_W]);
    end else if (mode_i != MODE_MARK && mode_i != MODE_DRAIN) begin
      drop = 1'b1;
    end
    div_start = accept && !drop && (mode_i != MODE_DRAIN);
    cs_eff    = (bin_size_q == '0) ? CS_W'(1) : bin_size_q;
  end

  gbcs_div u_div (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (div_start),
    .divisor_i    (cs_eff),
    .dividend_x_i (bin_x),
    .dividend_y_i (bin_y),
    .res_o        (div_res)
  );

  // Cell number from column and row quotients.
  always_comb begin
    prod    = div_res.qy * grid_cols_q;
    key_sum = KEY_W'(prod) + KEY_W'(div_res.qx);
  end

  // New entry for an offer.
  always_comb begin
    new_entry.x     = x_q;
    new_entry.y     = y_q;
    new_entry.level = lvl_q;
    new_entry.score = score_q;
  end

  // Sequencer and read-modify-write decisions.
  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    key_d       = key_q;
    ok_d        = ok_q;
    mem_we      = 1'b0;
    mem_wa      = key_q[IdxW-1:0];
    wr_word     = rd_q;
    res_valid_d = 1'b0;
    found_d     = 1'b0;
    unique case (state_q)
      ST_CLEAR: begin
        mem_we  = 1'b1;
        mem_wa  = clr_q;
        wr_word = '0;
        clr_d   = clr_q + 1'b1;
        if (clr_q == IdxW'(MAX_CELLS - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept && !drop) begin
          if (mode_i == MODE_DRAIN) begin
            key_d   = KEY_W'(cell_index_i);
            ok_d    = KEY_W'(cell_index_i) < MaxCellsK;
            state_d = ST_READ;
          end else begin
            state_d = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        if (div_res.done) begin
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        key_d   = key_sum;
        ok_d    = (div_res.qx < POS_W'(grid_cols_q)) && (key_sum < MaxCellsK);
        if (GC_W >= POS_W) begin
          ok_d = (GC_W'(div_res.qx) < grid_cols_q) && (key_sum < MaxCellsK);
        end
        state_d = ST_READ;
      end
      ST_READ: begin
        state_d = ST_MOD;
      end
      ST_MOD: begin
        state_d = ST_IDLE;
        if (mode_q == MODE_DRAIN) begin
          res_valid_d = 1'b1;
          found_d     = ok_q && rd_q.valid && (rd_q.entry.score > thresh_q);
          mem_we      = ok_q;
          wr_word     = '0;
        end else if (mode_q == MODE_MARK) begin
          mem_we           = ok_q;
          wr_word.occupied = 1'b1;
        end else begin
          mem_we = ok_q && !rd_q.occupied && (score_q > thresh_q)
                && (!rd_q.valid || (score_q > rd_q.entry.score));
          wr_word.valid = 1'b1;
          wr_word.entry = new_entry;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      res_valid_q <= res_valid_d;
    end
  end

  // Item and key registers.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      mode_q  <= mode_i;
      x_q     <= bin_x;
      y_q     <= bin_y;
      lvl_q   <= level_i;
      score_q <= score_i;
    end
    key_q <= key_d;
    ok_q  <= ok_d;
  end

  // Cell memory: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_wa] <= wr_word;
    end
    if (state_q == ST_READ) begin
      rd_q <= cell_word_t'(mem_q[key_q[IdxW-1:0]]);
    end
  end

  // Result beat payload, zero when nothing is found.
  always_ff @(posedge clk_i) begin
    if (res_valid_d) begin
      found_q   <= found_d;
      out_x_q   <= found_d ? rd_q.entry.x : '0;
      out_y_q   <= found_d ? rd_q.entry.y : '0;
      out_lvl_q <= found_d ? rd_q.entry.level : '0;
    end
  end

  assign result_valid_o = res_valid_q;
  assign found_o        = found_q;
  assign out_x_o        = out_x_q;
  assign out_y_o        = out_y_q;
  assign out_level_o    = out_lvl_q;

endmodule
